// File: hw/rtl/gmax_pkg.sv
// Shared constants, action codes and control structs for the grouped max block.
package gmax_pkg;

    // Default sizes handed to the top level parameters
    localparam int BIN_COUNT_DEF  = 1024;
    localparam int VALUE_BITS_DEF = 32;

    // Fixed field widths
    localparam int ACTION_W = 2;
    localparam int SAMPLE_W = 32;
    localparam int BIN_W    = 10;
    localparam int POS_W    = 32;
    localparam int CFG_W    = 11;

    // Reset value of the bins-in-use register
    localparam logic [CFG_W-1:0] BINS_RESET = 11'd1024;

    // Input action codes
    typedef enum logic [ACTION_W-1:0] {
        ACT_CLEAR = 2'd0,
        ACT_ACCUM = 2'd1,
        ACT_READ  = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    // Controller to datapath commands
    typedef struct packed {
        logic take;      // input transfer this cycle
        logic sweep_en;  // write one zero entry of the clearing pass
        logic finish;    // complete the held item this cycle
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic sweep_last; // clearing pass is at its final entry
        logic held_read;  // held item is a read
        logic out_busy;   // result register full and not taken this cycle
    } sts_t;

endpackage

// File: hw/rtl/gmax_ctrl.sv
// Controller state machine: input handshake, clearing pass and item sequencing.
module gmax_ctrl
    import gmax_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [ACTION_W-1:0] action,
    input  sts_t                sts,
    output cmd_t                cmd
);

    typedef enum logic [1:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_EVAL
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   take;
    logic   finish;

    // Decode handshake and completion
    assign in_ready = (state_reg == ST_IDLE);
    assign take     = in_valid && in_ready;
    assign finish   = (state_reg == ST_EVAL) && !(sts.held_read && sts.out_busy);

    assign cmd.take     = take;
    assign cmd.sweep_en = (state_reg == ST_SWEEP);
    assign cmd.finish   = finish;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_SWEEP:
            begin
                if (sts.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (take)
                begin
                    case (action)
                        ACT_CLEAR: state_next = ST_SWEEP;
                        ACT_ACCUM: state_next = ST_EVAL;
                        ACT_READ:  state_next = ST_EVAL;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_EVAL:
            begin
                if (finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_SWEEP;
        endcase
    end

    // Hold state; reset starts the clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_SWEEP;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: hw/rtl/gmax_dpath.sv
// Datapath: bin memory, sample counter, compare and update, result register.
module gmax_dpath
    import gmax_pkg::*;
#(
    parameter int BIN_COUNT  = BIN_COUNT_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cmd_t                       cmd,
    output sts_t                       sts,
    input  logic                       cfg_wr_en,
    input  logic [CFG_W-1:0]           cfg_wr_data,
    input  logic [ACTION_W-1:0]        action,
    input  logic signed [SAMPLE_W-1:0] sample_value,
    input  logic [BIN_W-1:0]           bin_number,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SAMPLE_W-1:0] max_value,
    output logic [POS_W-1:0]           max_position,
    output logic                       bin_empty
);

    localparam int IDX_W = $clog2(BIN_COUNT);
    localparam int ENT_W = 1 + VALUE_BITS + POS_W;
    localparam int CMP_W = ((IDX_W > BIN_W) ? IDX_W : BIN_W) + 1;

    // Entry layout: filled flag, maximum, position
    logic [ENT_W-1:0] mem [BIN_COUNT];
    logic [ENT_W-1:0] rd_reg;

    logic [CFG_W-1:0]            bins_in_use_reg;
    logic [POS_W-1:0]            counter_reg;
    logic [IDX_W-1:0]            sweep_reg;
    logic [ACTION_W-1:0]         action_reg;
    logic signed [VALUE_BITS-1:0] value_reg;
    logic [BIN_W-1:0]            bin_reg;
    logic                        out_valid_reg;
    logic signed [SAMPLE_W-1:0]  max_value_reg;
    logic [POS_W-1:0]            max_position_reg;
    logic                        bin_empty_reg;

    logic [CMP_W-1:0]             bin_in_ext;
    logic [CMP_W-1:0]             bin_held_ext;
    logic                         held_accum;
    logic                         held_read;
    logic                         in_count;
    logic                         in_use;
    logic                         filled;
    logic signed [VALUE_BITS-1:0] stored_max;
    logic [POS_W-1:0]             stored_pos;
    logic                         update;
    logic                         load_out;
    logic                         hit;

    // Widen bin numbers for range checks and addressing
    assign bin_in_ext   = CMP_W'(bin_number);
    assign bin_held_ext = CMP_W'(bin_reg);

    assign held_accum = (action_reg == ACT_ACCUM);
    assign held_read  = (action_reg == ACT_READ);
    assign in_count   = bin_held_ext < CMP_W'(BIN_COUNT);
    assign in_use     = in_count && (bin_held_ext < CMP_W'(bins_in_use_reg));

    // Split the entry read at transfer time
    assign filled     = rd_reg[ENT_W-1];
    assign stored_max = $signed(rd_reg[ENT_W-2 -: VALUE_BITS]);
    assign stored_pos = rd_reg[POS_W-1:0];

    // Take the sample if the bin is in use and is empty or the value is strictly greater
    assign update   = cmd.finish && held_accum && in_use
                      && (!filled || (value_reg > stored_max));
    assign load_out = cmd.finish && held_read;
    assign hit      = in_count && filled;

    assign sts.sweep_last = (sweep_reg == IDX_W'(BIN_COUNT - 1));
    assign sts.held_read  = held_read;
    assign sts.out_busy   = out_valid_reg && !out_ready;

    // Memory: clearing pass or update write, read at input transfer
    always_ff @(posedge clk)
    begin
        if (cmd.sweep_en)
        begin
            mem[sweep_reg] <= '0;
        end
        else if (update)
        begin
            mem[bin_held_ext[IDX_W-1:0]] <= {1'b1, value_reg, counter_reg};
        end
        if (cmd.take)
        begin
            rd_reg <= mem[bin_in_ext[IDX_W-1:0]];
        end
    end

    // Capture the item payload
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            action_reg <= action;
            value_reg  <= VALUE_BITS'(sample_value);
            bin_reg    <= bin_number;
        end
    end

    // Configuration, sample counter and clearing pass address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bins_in_use_reg <= BINS_RESET;
            counter_reg     <= '0;
            sweep_reg       <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                bins_in_use_reg <= cfg_wr_data;
            end
            if (cmd.take && (action == ACT_CLEAR))
            begin
                counter_reg <= '0;
            end
            else if (cmd.take && (action == ACT_ACCUM) && (counter_reg != '1))
            begin
                counter_reg <= counter_reg + 1'b1;
            end
            if (cmd.sweep_en)
            begin
                sweep_reg <= sts.sweep_last ? '0 : sweep_reg + 1'b1;
            end
        end
    end

    // Result valid: set on load, drop on output transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload; an empty or out-of-range bin reads as zeros
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            max_value_reg    <= hit ? SAMPLE_W'($unsigned(stored_max)) : '0;
            max_position_reg <= hit ? stored_pos : '0;
            bin_empty_reg    <= !hit;
        end
    end

    assign out_valid    = out_valid_reg;
    assign max_value    = max_value_reg;
    assign max_position = max_position_reg;
    assign bin_empty    = bin_empty_reg;

endmodule

// File: hw/rtl/grouped_max_with_argmax_core.sv
// Top level of the grouped maximum with argmax block.
//
//  Channel  Direction  Handshake              Payload
//  in       input      in_valid / in_ready    action, sample_value, bin_number
//  out      output     out_valid / out_ready  max_value, max_position, bin_empty
//  cfg      input      cfg_wr_en              cfg_wr_data (bins in use)
//
// Accumulate and read items run a read step, which fetches the bin entry from the
// bin memory as the item is taken, then an evaluate step to compare and write back
// or load the result. A clear item runs a clearing pass that zeroes the bin memory
// one entry a cycle; after reset the same clearing pass runs before in_ready rises.
// A read waits in its evaluate step while the result register is full and not taken;
// the result register lets the next item be taken while a result waits.
module grouped_max_with_argmax_core
    import gmax_pkg::*;
#(
    parameter int BIN_COUNT  = BIN_COUNT_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [CFG_W-1:0]           cfg_wr_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [ACTION_W-1:0]        action,
    input  logic signed [SAMPLE_W-1:0] sample_value,
    input  logic [BIN_W-1:0]           bin_number,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SAMPLE_W-1:0] max_value,
    output logic [POS_W-1:0]           max_position,
    output logic                       bin_empty
);

    cmd_t cmd;
    sts_t sts;

    // Sequencing
    gmax_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .action   (action),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Storage and arithmetic
    gmax_dpath #(
        .BIN_COUNT  (BIN_COUNT),
        .VALUE_BITS (VALUE_BITS)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .action       (action),
        .sample_value (sample_value),
        .bin_number   (bin_number),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .max_value    (max_value),
        .max_position (max_position),
        .bin_empty    (bin_empty)
    );

endmodule

// File: hw/rtl/gmax_checker.sv
// Port-level checker for the grouped maximum block and its bind to the top level.
module gmax_props
    import gmax_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic [ACTION_W-1:0]        action,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic signed [SAMPLE_W-1:0] max_value,
    input logic [POS_W-1:0]           max_position,
    input logic                       bin_empty
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(max_position))
        else $error("result dropped or changed while stalled");

    // One item at a time: any real item drops ready for the next cycle
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (action != ACT_NONE) |=> !in_ready)
        else $error("second item taken while one is at work");

    // An empty bin reads as zeros
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bin_empty |-> (max_value == '0) && (max_position == '0))
        else $error("empty bin returned non-zero fields");

    // A filled bin has a position counted from one
    a_pos_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !bin_empty |-> (max_position != '0))
        else $error("filled bin returned position zero");

endmodule

bind grouped_max_with_argmax_core gmax_props u_gmax_props (.*);

// File: tb/gmax_checker.sv
// Checker for the grouped max block: tracks each bin's peak and compares read results.
`timescale 1ns / 1ps

module gmax_checker
    import gmax_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [CFG_W-1:0]           cfg_wr_data,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic [ACTION_W-1:0]        action,
    input  logic signed [SAMPLE_W-1:0] sample_value,
    input  logic [BIN_W-1:0]           bin_number,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic signed [SAMPLE_W-1:0] max_value,
    input  logic [POS_W-1:0]           max_position,
    input  logic                       bin_empty,
    output int                         mismatches,
    output int                         reports_checked,
    output int                         results_pending
);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] peak;
        logic [POS_W-1:0]           position;
        logic                       empty;
    } bin_report_t;

    // Own copy of the bins, the sample counter and the bins-in-use register
    logic signed [SAMPLE_W-1:0] peak_store     [BIN_COUNT_DEF];
    logic [POS_W-1:0]           position_store [BIN_COUNT_DEF];
    bit                         filled         [BIN_COUNT_DEF];
    logic [POS_W-1:0]           sample_count;
    logic [CFG_W-1:0]           live_bins;
    bin_report_t                pending_reports [$];

    // Count the sample, then let it replace an in-use bin's peak if it is the first or strictly larger
    task automatic offer_sample(input logic signed [SAMPLE_W-1:0] value,
                                input logic [BIN_W-1:0] bin);
        if (sample_count != '1)
            sample_count = sample_count + 1'b1;
        if ({1'b0, bin} < live_bins && int'(bin) < BIN_COUNT_DEF)
        begin
            if (!filled[bin] || value > peak_store[bin])
            begin
                peak_store[bin]     = value;
                position_store[bin] = sample_count;
                filled[bin]         = 1'b1;
            end
        end
    endtask

    // Count one failure and print it
    task automatic flag(input string what, input logic [63:0] want, input logic [63:0] got);
        mismatches++;
        $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        bin_report_t want;
        bin_report_t got;
        if (!rst_n)
        begin
            foreach (filled[i])
                filled[i] = 1'b0;
            sample_count = '0;
            live_bins    = BINS_RESET;
            pending_reports.delete();
            mismatches      = 0;
            reports_checked = 0;
            results_pending = 0;
        end
        else
        begin
            // compare a result transfer with the oldest pending read
            if (out_valid && out_ready)
            begin
                got = '{peak: max_value, position: max_position, empty: bin_empty};
                if (pending_reports.size() == 0)
                    flag("unrequested result", '0, 64'(got));
                else
                begin
                    want = pending_reports.pop_front();
                    reports_checked++;
                    if (got.peak !== want.peak)
                        flag("max_value", 64'(want.peak), 64'(got.peak));
                    if (got.position !== want.position)
                        flag("max_position", 64'(want.position), 64'(got.position));
                    if (got.empty !== want.empty)
                        flag("bin_empty", 64'(want.empty), 64'(got.empty));
                end
            end

            // register write
            if (cfg_wr_en)
                live_bins = cfg_wr_data;

            // advance the bins on an input transfer
            if (in_valid && in_ready)
            begin
                case (action)
                    ACT_CLEAR:
                    begin
                        foreach (filled[i])
                            filled[i] = 1'b0;
                        sample_count = '0;
                    end
                    ACT_ACCUM:
                        offer_sample(sample_value, bin_number);
                    ACT_READ:
                    begin
                        if (filled[bin_number])
                            want = '{peak: peak_store[bin_number],
                                     position: position_store[bin_number], empty: 1'b0};
                        else
                            want = '{peak: '0, position: '0, empty: 1'b1};
                        pending_reports.push_back(want);
                    end
                    default:
                        ;
                endcase
            end
            results_pending = pending_reports.size();
        end
    end

endmodule

// File: tb/tb_grouped_max_with_argmax_core.sv
// Testbench top for the grouped max block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_grouped_max_with_argmax_core
    import gmax_pkg::*;
();

    localparam int CYCLE_LIMIT   = 300000;
    localparam int SETTLE_CYCLES = BIN_COUNT_DEF + 64;
    localparam int PHASES        = 7;
    localparam int PHASE_ITEMS   = 218;
    localparam int CALM_PHASE    = 5;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       cfg_wr_en;
    logic [CFG_W-1:0]           cfg_wr_data;
    logic                       in_valid;
    logic                       in_ready;
    logic [ACTION_W-1:0]        action;
    logic signed [SAMPLE_W-1:0] sample_value;
    logic [BIN_W-1:0]           bin_number;
    logic                       out_valid;
    logic                       out_ready;
    logic signed [SAMPLE_W-1:0] max_value;
    logic [POS_W-1:0]           max_position;
    logic                       bin_empty;

    int         mismatches;
    int         reports_checked;
    int         results_pending;
    int         cycles = 0;
    bit         calm = 1'b0;
    logic [CFG_W-1:0] live_setting = BINS_RESET;
    int         n_clears, n_samples, n_reads, n_unused;
    int         bins_plan [PHASES];

    always #4 clk = ~clk;

    grouped_max_with_argmax_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .sample_value (sample_value),
        .bin_number   (bin_number),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .max_value    (max_value),
        .max_position (max_position),
        .bin_empty    (bin_empty)
    );

    gmax_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .action          (action),
        .sample_value    (sample_value),
        .bin_number      (bin_number),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .max_value       (max_value),
        .max_position    (max_position),
        .bin_empty       (bin_empty),
        .mismatches      (mismatches),
        .reports_checked (reports_checked),
        .results_pending (results_pending)
    );

    // Stall the result side at random, except during the calm phase
    always @(posedge clk)
        out_ready <= calm || ($urandom_range(99) >= 16);

    // Give up on a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Offer one item and hold it until the transfer
    task automatic send_item(input action_t act, input logic signed [SAMPLE_W-1:0] value,
                             input logic [BIN_W-1:0] bin);
        while (!calm && $urandom_range(99) < 16)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        action       <= act;
        sample_value <= value;
        bin_number   <= bin;
        do
            @(posedge clk);
        while (!in_ready);
        case (act)
            ACT_CLEAR: n_clears++;
            ACT_ACCUM: n_samples++;
            ACT_READ:  n_reads++;
            default:   n_unused++;
        endcase
    endtask

    // Drop valid, wait for every read result, then let any clearing pass finish
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (results_pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_bins(input logic [CFG_W-1:0] setting);
        cfg_wr_en    <= 1'b1;
        cfg_wr_data  <= setting;
        live_setting  = setting;
        @(posedge clk);
        cfg_wr_en    <= 1'b0;
    endtask

    // Small values give ties, extremes hit the sign boundary, the rest is anything
    function automatic logic signed [SAMPLE_W-1:0] pick_value();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 35)
            return SAMPLE_W'(int'($urandom_range(8)) - 4);
        if (roll < 50)
        begin
            case ($urandom_range(3))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return '1;
                default: return '0;
            endcase
        end
        return $urandom;
    endfunction

    // Mostly a few hot bins, then bins around the in-use boundary, then any bin
    function automatic logic [BIN_W-1:0] pick_bin();
        int unsigned roll;
        int          border;
        roll = $urandom_range(99);
        if (roll < 55)
            return BIN_W'($urandom_range(7));
        if (roll < 80)
        begin
            border = int'(live_setting) + int'($urandom_range(3)) - 2;
            if (border < 0)
                border = 0;
            if (border > BIN_COUNT_DEF - 1)
                border = BIN_COUNT_DEF - 1;
            return BIN_W'(border);
        end
        return BIN_W'($urandom);
    endfunction

    task automatic send_random(input int count);
        int      done;
        int unsigned roll;
        action_t act;
        done = 0;
        while (done < count)
        begin
            roll = $urandom_range(99);
            if (roll < 3)
                act = ACT_CLEAR;
            else if (roll < 4)
                act = ACT_NONE;
            else if (roll < 60)
                act = ACT_ACCUM;
            else
                act = ACT_READ;
            send_item(act, pick_value(), pick_bin());
            if (act != ACT_NONE)
                done++;
        end
    endtask

    initial
    begin
        cfg_wr_en    <= 1'b0;
        cfg_wr_data  <= '0;
        in_valid     <= 1'b0;
        action       <= ACT_NONE;
        sample_value <= '0;
        bin_number   <= '0;
        rst_n        <= 1'b0;
        n_clears = 0;
        n_samples = 0;
        n_reads = 0;
        n_unused = 0;
        bins_plan = '{1024, 0, 1, 2047, 0, 1024, 13};
        bins_plan[4] = $urandom_range(2, 1023);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        // hold off while the block clears its bins after reset
        repeat (SETTLE_CYCLES) @(posedge clk);

        for (int p = 0; p < PHASES; p++)
        begin
            if (p > 0)
                wait_idle();
            calm = (p == CALM_PHASE);
            write_bins(CFG_W'(bins_plan[p]));
            if (p == 0)
            begin
                // empty read, minimum value, ties keep the first position
                send_item(ACT_READ,  '0, 10'd0);
                send_item(ACT_ACCUM, 32'h8000_0000, 10'd0);
                send_item(ACT_READ,  '0, 10'd0);
                send_item(ACT_ACCUM, 32'h8000_0000, 10'd0);
                send_item(ACT_READ,  '0, 10'd0);
                send_item(ACT_ACCUM, '1, 10'd0);
                send_item(ACT_ACCUM, '1, 10'd0);
                send_item(ACT_READ,  '0, 10'd0);
                // top bin, maximum value, smaller values do not replace it
                send_item(ACT_ACCUM, 32'h7FFF_FFFF, 10'd1023);
                send_item(ACT_ACCUM, 32'h7FFF_FFFE, 10'd1023);
                send_item(ACT_READ,  '0, 10'd1023);
                send_item(ACT_ACCUM, '0, 10'd1023);
                // alternating bit patterns
                send_item(ACT_ACCUM, 32'h5555_5555, 10'h155);
                send_item(ACT_ACCUM, 32'hAAAA_AAAA, 10'h2AA);
                send_item(ACT_READ,  '0, 10'h155);
                send_item(ACT_READ,  '0, 10'h2AA);
                // unused action changes nothing
                send_item(ACT_NONE,  32'h1234_5678, 10'd0);
                send_item(ACT_READ,  '0, 10'd0);
                // clear empties bins and restarts positions at one
                send_item(ACT_CLEAR, '0, 10'd0);
                send_item(ACT_READ,  '0, 10'd1023);
                send_item(ACT_ACCUM, '0, 10'd5);
                send_item(ACT_READ,  '0, 10'd5);
                send_item(ACT_READ,  '0, 10'd0);
            end
            send_random(PHASE_ITEMS);
        end
        wait_idle();

        $display("Covered %0d clears, %0d samples, %0d reads, %0d unused-action items",
                 n_clears, n_samples, n_reads, n_unused);
        $display("over %0d bins-in-use settings; %0d read results compared",
                 PHASES, reports_checked);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/gmax_pkg.sv
hw/rtl/gmax_ctrl.sv
hw/rtl/gmax_dpath.sv
hw/rtl/grouped_max_with_argmax_core.sv
hw/rtl/gmax_checker.sv
tb/gmax_checker.sv
tb/tb_grouped_max_with_argmax_core.sv
